// File: design/ymodem_crc_receiver_macros.svh
// ============================================================================
// ymodem_crc_receiver_macros : assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk, off in reset.
// ============================================================================
`ifndef YMODEM_CRC_RECEIVER_MACROS_SVH
`define YMODEM_CRC_RECEIVER_MACROS_SVH

// same-cycle implication
`define YCRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define YCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ycrc_pkg.sv
// ============================================================================
// ycrc_pkg : shared types and constants
// Byte codes, request and result records and the crc-16 step.
// ============================================================================
`default_nettype none

package ycrc_pkg;

    // operation codes
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // protocol bytes
    localparam logic [7:0] B_SOH  = 8'h01;
    localparam logic [7:0] B_STX  = 8'h02;
    localparam logic [7:0] B_EOT  = 8'h04;
    localparam logic [7:0] B_ACK  = 8'h06;
    localparam logic [7:0] B_NAK  = 8'h15;
    localparam logic [7:0] B_CA   = 8'h18;
    localparam logic [7:0] B_C    = 8'h43;
    localparam logic [7:0] B_ABT1 = 8'h41;
    localparam logic [7:0] B_ABT2 = 8'h61;
    localparam logic [7:0] B_PAD  = 8'h1A;
    localparam logic [7:0] B_NUL  = 8'h00;
    localparam logic [7:0] B_SPC  = 8'h20;
    localparam logic [7:0] B_D0   = 8'h30;
    localparam logic [7:0] B_D9   = 8'h39;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [10:0] LEN_SHORT = 11'd128;
    localparam logic [10:0] LEN_LONG  = 11'd1024;
    localparam logic [31:0] TRIM_WIN  = 32'd1024;
    localparam logic [7:0]  ERR_SAT   = 8'd255;
    localparam logic [7:0]  MAX_ERR_RST = 8'd5;

    // packet events
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_COMMIT  = 3'd1;
    localparam logic [2:0] EV_DISCARD = 3'd2;
    localparam logic [2:0] EV_HEADER  = 3'd3;
    localparam logic [2:0] EV_EOF     = 3'd4;
    localparam logic [2:0] EV_END     = 3'd5;
    localparam logic [2:0] EV_ABORT   = 3'd6;

    // session status
    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_ABORTED  = 3'd2;
    localparam logic [2:0] ST_ERR_ABT  = 3'd3;
    localparam logic [2:0] ST_SINK_ERR = 3'd4;

    // classified request
    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_TIMEOUT,
        CMD_RESTART,
        CMD_IGNORE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] rx_byte;
        logic       sink_refused;
    } t_cmd;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [31:0] data_offset;
        logic [2:0]  packet_event;
        logic [10:0] committed_length;
        logic [31:0] header_size;
        logic [1:0]  reply_count;
        logic [7:0]  reply_first;
        logic [7:0]  reply_second;
        logic [2:0]  session_status;
    } t_result;

    // one crc-16/xmodem byte step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/ycrc_if.sv
// ============================================================================
// ycrc_if : channel interfaces
// Input request, result and configuration channels with valid and ready.
// ============================================================================
`default_nettype none

interface ycrc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic       sink_refused;
    modport source (output valid, operation, rx_byte, sink_refused, input ready);
    modport sink (input valid, operation, rx_byte, sink_refused, output ready);
endinterface

interface ycrc_out_if;
    logic        valid;
    logic        ready;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [31:0] data_offset;
    logic [2:0]  packet_event;
    logic [10:0] committed_length;
    logic [31:0] header_size;
    logic [1:0]  reply_count;
    logic [7:0]  reply_first;
    logic [7:0]  reply_second;
    logic [2:0]  session_status;
    modport source (output valid, data_valid, data_byte, data_offset, packet_event,
                    committed_length, header_size, reply_count, reply_first,
                    reply_second, session_status, input ready);
    modport sink (input valid, data_valid, data_byte, data_offset, packet_event,
                  committed_length, header_size, reply_count, reply_first,
                  reply_second, session_status, output ready);
endinterface

interface ycrc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: design/ycrc_front.sv
// ============================================================================
// ycrc_front : request intake
// Classifies each request and holds it in a two-entry queue for the back end.
// ============================================================================
`default_nettype none

module ycrc_front
    import ycrc_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    ycrc_in_if.sink      i_item,
    input  wire          i_pop,
    output t_cmd         o_cmd,
    output logic         o_cmd_valid
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // classify the incoming request
    always_comb begin
        w_cmd.rx_byte      = i_item.rx_byte;
        w_cmd.sink_refused = i_item.sink_refused;
        case (i_item.operation)
            OP_BYTE:    w_cmd.kind = CMD_BYTE;
            OP_TIMEOUT: w_cmd.kind = CMD_TIMEOUT;
            OP_RESTART: w_cmd.kind = CMD_RESTART;
            default:    w_cmd.kind = CMD_IGNORE;
        endcase
    end

    assign i_item.ready = (r_count != 2'd2);
    assign w_push       = i_item.valid && i_item.ready;
    assign w_pop        = i_pop && (r_count != 2'd0);
    assign o_cmd_valid  = (r_count != 2'd0);
    assign o_cmd        = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

`default_nettype wire

// File: design/ycrc_back.sv
// ============================================================================
// ycrc_back : protocol engine
// Packet framing, crc check, header parse, replies and the result register.
// ============================================================================
`default_nettype none

module ycrc_back
    import ycrc_pkg::*;
#(
    parameter int SIZE_DIGITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire t_cmd    i_cmd,
    input  wire          i_cmd_valid,
    output logic         o_pop,
    ycrc_cfg_if.sink     i_cfg,
    ycrc_out_if.source   o_result
);

    localparam int DW = $clog2(SIZE_DIGITS + 1);

    typedef enum logic [3:0] {
        PH_START, PH_CA2, PH_BLK, PH_CBLK, PH_DATA, PH_CRCH, PH_CRCL, PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        HF_NAME, HF_SIZE, HF_END
    } t_hfield;

    t_phase      r_phase, n_phase;
    logic [10:0] r_pos, n_pos;
    logic        r_long, n_long;
    logic [7:0]  r_blk, n_blk;
    logic [7:0]  r_seq, n_seq;
    logic        r_hdr_exp, n_hdr_exp;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic [7:0]  r_err, n_err;
    logic        r_begun, n_begun;
    logic [31:0] r_bytes, n_bytes;
    logic [31:0] r_parsed, n_parsed;
    logic [31:0] r_fsize, n_fsize;
    t_hfield     r_hfield, n_hfield;
    logic [DW-1:0] r_digits, n_digits;
    logic [10:0] r_keep, n_keep;
    logic        r_trim, n_trim;
    logic        r_hdr_empty, n_hdr_empty;
    logic [2:0]  r_status, n_status;
    logic        r_cblk_bad, n_cblk_bad;
    logic [7:0]  r_max_err;
    t_result     r_out, n_out;
    logic        r_out_valid;

    logic        w_take;
    logic        w_fail;
    logic [2:0]  w_fail_ev;
    logic [7:0]  w_b;
    logic [7:0]  w_err_inc;
    logic [10:0] w_plen;
    logic [10:0] w_len;
    logic [10:0] w_pos_inc;
    logic [15:0] w_rx_full;

    assign w_take = i_cmd_valid && (!r_out_valid || o_result.ready);
    assign o_pop  = w_take;
    assign i_cfg.ready = 1'b1;
    assign w_b       = i_cmd.rx_byte;
    assign w_plen    = r_long ? LEN_LONG : LEN_SHORT;
    assign w_len     = r_trim ? r_keep : w_plen;
    assign w_pos_inc = r_pos + 11'd1;
    assign w_rx_full = {r_rx_crc[15:8], w_b};
    assign w_err_inc = (r_begun && r_err < ERR_SAT) ? r_err + 8'd1 : r_err;

    // next state and result for one request
    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_long = r_long; n_blk = r_blk;
        n_seq = r_seq; n_hdr_exp = r_hdr_exp; n_crc = r_crc; n_rx_crc = r_rx_crc;
        n_err = r_err; n_begun = r_begun; n_bytes = r_bytes; n_parsed = r_parsed;
        n_fsize = r_fsize; n_hfield = r_hfield; n_digits = r_digits; n_keep = r_keep;
        n_trim = r_trim; n_hdr_empty = r_hdr_empty; n_status = r_status;
        n_cblk_bad = r_cblk_bad;
        n_out = '0;
        w_fail = 1'b0;
        w_fail_ev = EV_NONE;

        case (i_cmd.kind)
            CMD_RESTART: begin
                n_phase = PH_START; n_pos = '0; n_long = 1'b0; n_blk = '0;
                n_seq = '0; n_hdr_exp = 1'b1; n_crc = '0; n_rx_crc = '0;
                n_err = '0; n_begun = 1'b0; n_bytes = '0; n_parsed = '0;
                n_fsize = '0; n_hfield = HF_NAME; n_digits = '0; n_keep = '0;
                n_trim = 1'b0; n_hdr_empty = 1'b0; n_status = ST_RUN;
                n_cblk_bad = 1'b0;
            end
            CMD_TIMEOUT: begin
                if (r_phase != PH_STOP) begin
                    w_fail = 1'b1;
                    w_fail_ev = (r_phase == PH_BLK || r_phase == PH_CBLK ||
                                 r_phase == PH_DATA || r_phase == PH_CRCH ||
                                 r_phase == PH_CRCL) ? EV_DISCARD : EV_NONE;
                end
            end
            CMD_BYTE: begin
                case (r_phase)
                    PH_START: begin
                        if (w_b == B_SOH || w_b == B_STX) begin
                            n_long  = (w_b == B_STX);
                            n_phase = PH_BLK;
                        end else if (w_b == B_EOT) begin
                            n_err = '0;
                            n_out.reply_count = 2'd1;
                            n_out.reply_first = B_ACK;
                            n_hdr_exp = 1'b1;
                            n_seq = '0;
                            n_out.packet_event = EV_EOF;
                        end else if (w_b == B_CA) begin
                            n_phase = PH_CA2;
                        end else if (w_b == B_ABT1 || w_b == B_ABT2) begin
                            n_out.reply_count  = 2'd2;
                            n_out.reply_first  = B_CA;
                            n_out.reply_second = B_CA;
                            n_status = ST_ABORTED;
                            n_phase  = PH_STOP;
                            n_out.packet_event = EV_ABORT;
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                    PH_CA2: begin
                        if (w_b == B_CA) begin
                            n_err = '0;
                            n_out.reply_count = 2'd1;
                            n_out.reply_first = B_ACK;
                            n_status = ST_ABORTED;
                            n_phase  = PH_STOP;
                            n_out.packet_event = EV_ABORT;
                        end else begin
                            w_fail = 1'b1;
                        end
                    end
                    PH_BLK: begin
                        n_blk   = w_b;
                        n_phase = PH_CBLK;
                    end
                    PH_CBLK: begin
                        n_cblk_bad = (r_blk != ~w_b);
                        n_pos = '0; n_crc = '0; n_keep = '0;
                        n_hfield = HF_NAME; n_digits = '0; n_parsed = '0;
                        n_hdr_empty = 1'b0;
                        n_trim  = (r_fsize - r_bytes) < TRIM_WIN;
                        n_phase = PH_DATA;
                    end
                    PH_DATA: begin
                        n_crc = crc_byte(r_crc, w_b);
                        if (r_hdr_exp) begin
                            if (r_pos == '0) begin
                                n_hdr_empty = (w_b == B_NUL);
                            end
                            case (r_hfield)
                                HF_NAME: begin
                                    if (w_b == B_NUL) begin
                                        n_hfield = HF_SIZE;
                                        n_digits = '0;
                                        n_parsed = '0;
                                    end
                                end
                                HF_SIZE: begin
                                    if (r_digits >= DW'(SIZE_DIGITS) || w_b == B_SPC) begin
                                        n_hfield = HF_END;
                                    end else begin
                                        n_digits = r_digits + DW'(1);
                                        if (w_b >= B_D0 && w_b <= B_D9) begin
                                            n_parsed = {r_parsed[28:0], 3'b000}
                                                     + {r_parsed[30:0], 1'b0}
                                                     + {24'd0, w_b - B_D0};
                                        end else begin
                                            n_hfield = HF_END;
                                        end
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end else begin
                            n_out.data_valid  = 1'b1;
                            n_out.data_byte   = w_b;
                            n_out.data_offset = r_bytes + {21'd0, r_pos};
                            if (w_b != B_PAD) begin
                                n_keep = w_pos_inc;
                            end
                        end
                        n_pos = w_pos_inc;
                        if (w_pos_inc >= w_plen) begin
                            n_phase = PH_CRCH;
                        end
                    end
                    PH_CRCH: begin
                        n_rx_crc = {w_b, 8'h00};
                        n_phase  = PH_CRCL;
                    end
                    PH_CRCL: begin
                        n_rx_crc = w_rx_full;
                        n_phase  = PH_START;
                        if (r_cblk_bad || r_crc != w_rx_full) begin
                            w_fail = 1'b1;
                            w_fail_ev = EV_DISCARD;
                        end else begin
                            n_err = '0;
                            if (r_blk != r_seq) begin
                                n_out.reply_count = 2'd1;
                                n_out.reply_first = B_NAK;
                                n_out.packet_event = EV_DISCARD;
                            end else if (r_hdr_exp) begin
                                if (r_hdr_empty) begin
                                    n_out.reply_count = 2'd1;
                                    n_out.reply_first = B_ACK;
                                    n_status = ST_DONE;
                                    n_phase  = PH_STOP;
                                    n_out.packet_event = EV_END;
                                end else begin
                                    n_fsize = r_parsed;
                                    n_bytes = '0;
                                    n_hdr_exp = 1'b0;
                                    n_seq = 8'd1;
                                    n_begun = 1'b1;
                                    n_out.reply_count  = 2'd2;
                                    n_out.reply_first  = B_ACK;
                                    n_out.reply_second = B_C;
                                    n_out.packet_event = EV_HEADER;
                                    n_out.header_size  = r_parsed;
                                end
                            end else if (i_cmd.sink_refused) begin
                                n_out.reply_count  = 2'd2;
                                n_out.reply_first  = B_CA;
                                n_out.reply_second = B_CA;
                                n_status = ST_SINK_ERR;
                                n_phase  = PH_STOP;
                                n_out.packet_event = EV_ABORT;
                            end else begin
                                n_bytes = r_bytes + {21'd0, w_len};
                                n_seq   = r_seq + 8'd1;
                                n_begun = 1'b1;
                                n_out.reply_count = 2'd1;
                                n_out.reply_first = B_ACK;
                                n_out.packet_event     = EV_COMMIT;
                                n_out.committed_length = w_len;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        // error accounting and abort on limit
        if (w_fail) begin
            n_phase = PH_START;
            n_err   = w_err_inc;
            if (w_err_inc > r_max_err) begin
                n_out.reply_count  = 2'd2;
                n_out.reply_first  = B_CA;
                n_out.reply_second = B_CA;
                n_status = ST_ERR_ABT;
                n_phase  = PH_STOP;
                n_out.packet_event = EV_ABORT;
            end else begin
                n_out.reply_count  = 2'd1;
                n_out.reply_first  = B_C;
                n_out.packet_event = w_fail_ev;
            end
        end
        n_out.session_status = n_status;
    end

    // session state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START; r_pos <= '0; r_long <= 1'b0; r_blk <= '0;
            r_seq <= '0; r_hdr_exp <= 1'b1; r_crc <= '0; r_rx_crc <= '0;
            r_err <= '0; r_begun <= 1'b0; r_bytes <= '0; r_parsed <= '0;
            r_fsize <= '0; r_hfield <= HF_NAME; r_digits <= '0; r_keep <= '0;
            r_trim <= 1'b0; r_hdr_empty <= 1'b0; r_status <= ST_RUN;
            r_cblk_bad <= 1'b0; r_max_err <= MAX_ERR_RST; r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_max_err <= i_cfg.data;
            end
            if (w_take) begin
                r_phase <= n_phase; r_pos <= n_pos; r_long <= n_long; r_blk <= n_blk;
                r_seq <= n_seq; r_hdr_exp <= n_hdr_exp; r_crc <= n_crc;
                r_rx_crc <= n_rx_crc; r_err <= n_err; r_begun <= n_begun;
                r_bytes <= n_bytes; r_parsed <= n_parsed; r_fsize <= n_fsize;
                r_hfield <= n_hfield; r_digits <= n_digits; r_keep <= n_keep;
                r_trim <= n_trim; r_hdr_empty <= n_hdr_empty; r_status <= n_status;
                r_cblk_bad <= n_cblk_bad;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.data_valid       = r_out.data_valid;
    assign o_result.data_byte        = r_out.data_byte;
    assign o_result.data_offset      = r_out.data_offset;
    assign o_result.packet_event     = r_out.packet_event;
    assign o_result.committed_length = r_out.committed_length;
    assign o_result.header_size      = r_out.header_size;
    assign o_result.reply_count      = r_out.reply_count;
    assign o_result.reply_first      = r_out.reply_first;
    assign o_result.reply_second     = r_out.reply_second;
    assign o_result.session_status   = r_out.session_status;

endmodule

`default_nettype wire

// File: design/ymodem_crc_receiver.sv
// result path: intake queue, then the protocol engine, then the registered result port
// throughput: one request per cycle while the result port is ready, set by the protocol engine
// a two-entry queue lets intake continue while a result waits to be taken
// reset: synchronous active low, session idle, error limit back to 5
// ============================================================================
// ymodem_crc_receiver : ymodem-crc receiver top level
// Intake queue feeding the protocol engine with a registered result port.
// ============================================================================
`default_nettype none

module ymodem_crc_receiver
    import ycrc_pkg::*;
#(
    parameter int SIZE_DIGITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ycrc_in_if.sink      i_item,
    ycrc_cfg_if.sink     i_cfg,
    ycrc_out_if.source   o_result
);

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_pop;

    // request intake
    ycrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_pop       (w_pop),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid)
    );

    // protocol engine
    ycrc_back #(
        .SIZE_DIGITS (SIZE_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_pop       (w_pop),
        .i_cfg       (i_cfg),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// File: design/ycrc_checker.sv
// ============================================================================
// ycrc_checker : port-level checks
// Watches the result channel of the receiver and is bound to the top level.
// ============================================================================
`default_nettype none
`include "ymodem_crc_receiver_macros.svh"

module ycrc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        i_ready,
    input wire        i_data_valid,
    input wire [7:0]  i_data_byte,
    input wire [2:0]  i_packet_event,
    input wire [10:0] i_committed_length,
    input wire [1:0]  i_reply_count,
    input wire [7:0]  i_reply_first,
    input wire [7:0]  i_reply_second
);

    // stalled result holds
    `YCRC_ASSERT_NEXT(a_hold, i_valid && !i_ready, i_valid && $stable(i_data_byte) && $stable(i_packet_event), "result changed under stall")

    // a data byte carries no event and no reply
    `YCRC_ASSERT_NOW(a_data_quiet, i_valid && i_data_valid, i_packet_event == 3'd0 && i_reply_count == 2'd0, "data byte with event or reply")

    // unused reply bytes are zero
    `YCRC_ASSERT_NOW(a_reply_zero, i_valid && i_reply_count == 2'd0, i_reply_first == 8'd0 && i_reply_second == 8'd0, "stray reply byte")

    // length only with a commit
    `YCRC_ASSERT_NOW(a_len_commit, i_valid && i_packet_event != 3'd1, i_committed_length == 11'd0, "length without commit")

endmodule

bind ymodem_crc_receiver ycrc_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (o_result.valid),
    .i_ready            (o_result.ready),
    .i_data_valid       (o_result.data_valid),
    .i_data_byte        (o_result.data_byte),
    .i_packet_event     (o_result.packet_event),
    .i_committed_length (o_result.committed_length),
    .i_reply_count      (o_result.reply_count),
    .i_reply_first      (o_result.reply_first),
    .i_reply_second     (o_result.reply_second)
);

`default_nettype wire
